@@ hdl/lpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared constants and types for the lru page cache and its entry cells.
// ----------------------------------------------------------------------------
package lpc_pkg;

  localparam int ENTRIES = 8;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 4;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int TAG_W   = 32;
  localparam int DATA_W  = 64;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [DATA_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic occupied;
    logic load;
  } cell_ctl_t;

endpackage

@@ hdl/lpc_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_req_if
// Request channel: page tag and fill data with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lpc_req_if;
  import lpc_pkg::*;

  logic              valid;
  logic              ready;
  logic [TAG_W-1:0]  page_tag;
  logic [DATA_W-1:0] fill_data;

  modport source (output valid, output page_tag, output fill_data, input ready);
  modport sink   (input valid, input page_tag, input fill_data, output ready);

endinterface

@@ hdl/lpc_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_rsp_if
// Response channel: hit flag, page data and eviction report.
// ----------------------------------------------------------------------------
interface lpc_rsp_if;
  import lpc_pkg::*;

  logic              valid;
  logic              ready;
  logic              hit;
  logic [DATA_W-1:0] page_data;
  logic              evicted;
  logic [31:0]       evicted_tag;

  modport source (output valid, output hit, output page_data, output evicted,
                  output evicted_tag, input ready);
  modport sink   (input valid, input hit, input page_data, input evicted,
                  input evicted_tag, output ready);

endinterface

@@ hdl/lpc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_cell
// One recency position of the cache: holds an entry, compares its tag and
// takes the entry of its more recent neighbor when told to shift.
// ----------------------------------------------------------------------------
module lpc_cell (
  input  logic                      clk,
  input  lpc_pkg::cell_ctl_t        ctl,
  input  lpc_pkg::entry_t           entry_in,
  input  logic [lpc_pkg::TAG_W-1:0] req_tag,
  output lpc_pkg::entry_t           entry,
  output logic                      match
);
  import lpc_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry <= entry_in;
    end
  end

  assign match = ctl.occupied && (entry.tag == req_tag);

endmodule

@@ hdl/lru_page_cache.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_cache
// Fully associative page cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   req carries a page tag and the fill data backing memory would return.
//   rsp returns one item per request: hit flag, page data (stored data on
//   a hit, fill data on a miss), and the evicted flag and tag on a miss
//   that replaced the least recent entry.
//   cfg_we / cfg_wdata set the capacity in use (0 acts as 1, values above
//   the entry count act as the entry count); write it only while idle.
//   The response is registered and becomes valid in the cycle after acceptance.
//   Throughput is one item per cycle unless rsp stalls: all entry tags are
//   compared at once; the cells shift in the same cycle the request is taken.
//   When the receiver stalls, the response is held and req.ready drops
//   until it is taken; req.ready is high again in the cycle it is taken.
//   Reset empties the cache and sets the capacity to the entry count.
// ----------------------------------------------------------------------------
module lru_page_cache (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [lpc_pkg::CAP_W-1:0] cfg_wdata,
  lpc_req_if.sink                   req,
  lpc_rsp_if.source                 rsp
);
  import lpc_pkg::*;

  logic [CAP_W-1:0] capacity;
  logic [CNT_W-1:0] occ;
  logic [CNT_W-1:0] occ_next;

  entry_t     cell_entry [ENTRIES];
  entry_t     cell_in    [ENTRIES];
  cell_ctl_t  cell_ctl   [ENTRIES];
  logic [ENTRIES-1:0] match;

  logic              accept;
  logic              hit;
  logic [CNT_W-1:0]  hit_pos;
  logic [DATA_W-1:0] hit_data;
  logic [CMP_W-1:0]  eff_cap;
  logic              full;
  logic [CNT_W-1:0]  pos;
  logic [TAG_W-1:0]  victim_tag;
  logic [CNT_W-1:0]  last_pos;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(ENTRIES);
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // hit search, lowest position wins
  always_comb begin
    hit      = 1'b0;
    hit_pos  = '0;
    hit_data = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit      = 1'b1;
        hit_pos  = CNT_W'(i);
        hit_data = cell_entry[i].data;
      end
    end
  end

  assign last_pos = occ - CNT_W'(1);

  always_comb begin
    victim_tag = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (CNT_W'(i) == last_pos) begin
        victim_tag = cell_entry[i].tag;
      end
    end
  end

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = CMP_W'(capacity);
    end
  end

  assign full = CMP_W'(occ) >= eff_cap;

  always_comb begin
    if (hit) begin
      pos      = hit_pos;
      occ_next = occ;
    end else if (full) begin
      pos      = last_pos;
      occ_next = occ;
    end else begin
      pos      = occ;
      occ_next = occ + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (accept) begin
      occ <= occ_next;
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_in[i].tag  = req.page_tag;
      assign cell_in[i].data = hit ? hit_data : req.fill_data;
    end else begin : g_body
      assign cell_in[i] = cell_entry[i-1];
    end

    assign cell_ctl[i].occupied = CNT_W'(i) < occ;
    assign cell_ctl[i].load     = accept && (CNT_W'(i) <= pos);

    lpc_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl[i]),
      .entry_in (cell_in[i]),
      .req_tag  (req.page_tag),
      .entry    (cell_entry[i]),
      .match    (match[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.hit         <= hit;
      rsp.page_data   <= hit ? hit_data : req.fill_data;
      rsp.evicted     <= !hit && full;
      rsp.evicted_tag <= (!hit && full) ? victim_tag[31:0] : 32'd0;
    end
  end

endmodule

@@ verif/tb_lru_page_cache.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_page_cache
// Drives page requests with random gaps on both channels. A predictor
// tracks tags, data and recency order and checks each response in order:
// hit flag, page data and the eviction report. Capacities are changed
// between phases, including zero, values above the entry count, and
// lowering below the current occupancy.
// ----------------------------------------------------------------------------
module tb_lru_page_cache;
  import lpc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int GAP_PCT     = 36;
  localparam int TAG_POOL    = 12;
  localparam int PHASE_ITEMS = 94;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [DATA_W-1:0] data;
  } page_req_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] data;
    logic              evicted;
    logic [31:0]       evicted_tag;
  } lookup_rsp_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  lpc_req_if req ();
  lpc_rsp_if rsp ();

  lru_page_cache DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp)
  );

  // predicted cache contents
  logic [TAG_W-1:0]  cached_tag  [ENTRIES];
  logic [DATA_W-1:0] cached_data [ENTRIES];
  logic [IDX_W-1:0]  recency     [ENTRIES];
  int                filled;
  logic [CAP_W-1:0]  capacity;

  page_req_t         pending_reqs [$];
  lookup_rsp_t       expected_rsps [$];
  page_req_t         on_bus;
  logic [TAG_W-1:0]  tag_pool [TAG_POOL];
  logic [TAG_W-1:0]  last_tag;
  bit                no_gaps = 1'b0;
  int                mismatches = 0;
  int                cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void move_to_front(int pos);
    logic [IDX_W-1:0] slot;
    slot = recency[pos];
    for (int i = pos; i > 0; i--) recency[i] = recency[i-1];
    recency[0] = slot;
  endfunction

  function automatic lookup_rsp_t cache_lookup(page_req_t rq);
    lookup_rsp_t      r;
    int               limit;
    int               pos;
    logic [IDX_W-1:0] slot;
    limit = capacity;
    if (limit == 0) limit = 1;
    if (limit > ENTRIES) limit = ENTRIES;
    for (int p = 0; p < filled; p++) begin
      slot = recency[p];
      if (cached_tag[slot] == rq.tag) begin
        move_to_front(p);
        r.hit         = 1'b1;
        r.data        = cached_data[slot];
        r.evicted     = 1'b0;
        r.evicted_tag = '0;
        return r;
      end
    end
    r.hit  = 1'b0;
    r.data = rq.data;
    if (filled >= limit) begin
      pos           = filled - 1;
      slot          = recency[pos];
      r.evicted     = 1'b1;
      r.evicted_tag = cached_tag[slot][31:0];
    end else begin
      pos           = filled;
      slot          = recency[pos];
      r.evicted     = 1'b0;
      r.evicted_tag = '0;
      filled++;
    end
    cached_tag[slot]  = rq.tag;
    cached_data[slot] = rq.data;
    move_to_front(pos);
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) expected_rsps.push_back(cache_lookup(on_bus));
      if (!req.valid || req.ready) begin
        if (pending_reqs.size() != 0 && (no_gaps || $urandom_range(99) >= GAP_PCT)) begin
          on_bus = pending_reqs.pop_front();
          req.valid     <= 1'b1;
          req.page_tag  <= on_bus.tag;
          req.fill_data <= on_bus.data;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    lookup_rsp_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: hit=%0b data=%h evicted=%0b tag=%h",
                     rsp.hit, rsp.page_data, rsp.evicted, rsp.evicted_tag);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.hit !== want.hit || rsp.page_data !== want.data ||
              rsp.evicted !== want.evicted || rsp.evicted_tag !== want.evicted_tag) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("mismatch: expected hit=%0b data=%h evicted=%0b tag=%h,",
                     want.hit, want.data, want.evicted, want.evicted_tag);
              $display(" got hit=%0b data=%h evicted=%0b tag=%h",
                       rsp.hit, rsp.page_data, rsp.evicted, rsp.evicted_tag);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || req.valid || expected_rsps.size() != 0)
      @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    capacity = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_item(logic [TAG_W-1:0] tag, logic [DATA_W-1:0] data);
    page_req_t rq;
    rq.tag  = tag;
    rq.data = data;
    pending_reqs.push_back(rq);
  endtask

  task automatic queue_random(int count);
    page_req_t rq;
    int        r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 20) rq.tag = last_tag;
      else if (r < 80) rq.tag = tag_pool[$urandom_range(TAG_POOL-1)];
      else rq.tag = $urandom;
      last_tag = rq.tag;
      r = $urandom_range(9);
      if (r == 0) rq.data = '0;
      else if (r == 1) rq.data = '1;
      else rq.data = {$urandom, $urandom};
      pending_reqs.push_back(rq);
    end
  endtask

  initial begin
    logic [CAP_W-1:0] phase_caps [10];
    phase_caps = '{4'd4, 4'd6, 4'd15, 4'd2, 4'd1, 4'd0, 4'd9, 4'd8, 4'd12, 4'd8};

    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    req.valid     = 1'b0;
    req.page_tag  = '0;
    req.fill_data = '0;
    rsp.ready     = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      recency[i]     = IDX_W'(i);
      cached_tag[i]  = '0;
      cached_data[i] = '0;
    end
    filled   = 0;
    capacity = CAP_W'(ENTRIES);
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < TAG_POOL; i++) tag_pool[i] = $urandom;
    last_tag = tag_pool[0];

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // capacity zero acts as one entry
    write_capacity('0);
    queue_item('0, '0);
    queue_item('0, '1);
    queue_item('1, '1);
    queue_item('1, '0);
    queue_item('0, 64'h5555_5555_5555_5555);
    queue_item(32'hA5A5_A5A5, 64'hAAAA_AAAA_AAAA_AAAA);

    // fill to three, hit the least recent entry, then evict
    write_capacity(4'd3);
    queue_item(32'h0000_0001, 64'h0123_4567_89AB_CDEF);
    queue_item(32'h8000_0000, 64'h8000_0000_0000_0001);
    queue_item(32'hA5A5_A5A5, '0);
    queue_item(32'h5A5A_5A5A, 64'hFEDC_BA98_7654_3210);
    queue_item(32'h8000_0000, '1);
    queue_item(32'h0000_0001, '1);

    for (int ph = 0; ph < 10; ph++) begin
      write_capacity(phase_caps[ph]);
      no_gaps = (ph == 2);
      queue_random(PHASE_ITEMS);
    end

    wait_idle();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
